@@ hw/rtl/aff2d_pkg.sv @@
`default_nettype none
package aff2d_pkg;
    localparam int EntryWidth = 32;
    localparam int FracWidth = 5;
    localparam logic [FracWidth-1:0] FracReset = 5'd16;
    localparam int NumQuot = 6;

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
    } t_in;

    typedef struct packed {
        logic               status;
        logic signed [31:0] determinant;
        logic signed [31:0] b00;
        logic signed [31:0] b01;
        logic signed [31:0] b02;
        logic signed [31:0] b10;
        logic signed [31:0] b11;
        logic signed [31:0] b12;
    } t_out;
endpackage
`default_nettype wire

@@ hw/rtl/aff2d_front.sv @@
`default_nettype none
module aff2d_front #(
    parameter int W = aff2d_pkg::EntryWidth
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [4:0]           i_frac,
    input  wire logic signed [W-1:0]  i_a00,
    input  wire logic signed [W-1:0]  i_a01,
    input  wire logic signed [W-1:0]  i_a02,
    input  wire logic signed [W-1:0]  i_a10,
    input  wire logic signed [W-1:0]  i_a11,
    input  wire logic signed [W-1:0]  i_a12,
    output logic signed [W-1:0]       o_d,
    output logic [6*W-1:0]            o_num
);
    import aff2d_pkg::*;
    localparam logic signed [2*W:0] Mx = (2*W+1)'((64'd1 << (W-1)) - 64'd1);

    logic signed [2*W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [W-1:0] r_n0, r_n1, r_n3, r_n4;
    logic [4:0] r_frac;

    function automatic logic signed [W-1:0] sat(input logic signed [2*W:0] x);
        if (x > Mx) sat = Mx[W-1:0];
        else if (x < -Mx) sat = -Mx[W-1:0];
        else sat = x[W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_a00 * i_a11;
            r_p1 <= i_a01 * i_a10;
            r_p2 <= i_a01 * i_a12;
            r_p3 <= i_a02 * i_a11;
            r_p4 <= i_a02 * i_a10;
            r_p5 <= i_a00 * i_a12;
            r_n0 <= i_a11 <<< i_frac;
            r_n1 <= (-i_a01) <<< i_frac;
            r_n3 <= (-i_a10) <<< i_frac;
            r_n4 <= i_a00 <<< i_frac;
            r_frac <= i_frac;
        end
    end

    logic signed [W-1:0] s0, s1, s2, s3, s4, s5, s, n2, n5;
    always_comb begin
        s0 = sat((2*W+1)'(r_p0));
        s1 = sat((2*W+1)'(r_p1));
        s2 = sat((2*W+1)'(r_p2));
        s3 = sat((2*W+1)'(r_p3));
        s4 = sat((2*W+1)'(r_p4));
        s5 = sat((2*W+1)'(r_p5));
        s  = sat((2*W+1)'(s0) - (2*W+1)'(s1));
        n2 = sat((2*W+1)'(s2) - (2*W+1)'(s3));
        n5 = sat((2*W+1)'(s4) - (2*W+1)'(s5));
        o_d = s >>> r_frac;
        o_num = {r_n0, r_n1, n2, r_n3, r_n4, n5};
    end
endmodule
`default_nettype wire

@@ hw/rtl/aff2d_cell.sv @@
`default_nettype none
module aff2d_cell #(
    parameter int W = aff2d_pkg::EntryWidth,
    parameter int N = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [W-1:0]      i_dabs,
    input  wire logic [N*W-1:0]    i_rem,
    input  wire logic [N*W-1:0]    i_num,
    input  wire logic [N*W-1:0]    i_quo,
    output logic [W-1:0]           o_dabs,
    output logic [N*W-1:0]         o_rem,
    output logic [N*W-1:0]         o_num,
    output logic [N*W-1:0]         o_quo
);
    logic [N*W-1:0] n_rem, n_num, n_quo;
    always_comb begin
        for (int k = 0; k < N; k++) begin
            logic [W:0] t;
            t = {i_rem[k*W +: W], i_num[k*W+W-1]};
            if (t >= {1'b0, i_dabs}) begin
                t = t - {1'b0, i_dabs};
                n_quo[k*W +: W] = {i_quo[k*W +: W-1], 1'b1};
            end else begin
                n_quo[k*W +: W] = {i_quo[k*W +: W-1], 1'b0};
            end
            n_rem[k*W +: W] = t[W-1:0];
            n_num[k*W +: W] = {i_num[k*W +: W-1], 1'b0};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dabs <= i_dabs;
            o_rem <= n_rem;
            o_num <= n_num;
            o_quo <= n_quo;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/affine_2d_matrix_inverse_fixed.sv @@
// Inverse of a 2D affine matrix in fixed point. Accepts one matrix per cycle
// and returns one result per matrix; the pipe holds two product and sign
// stages plus one restoring divide cell per quotient bit, all six quotients
// in parallel. The whole pipe stalls while the output is held.
`default_nettype none
module affine_2d_matrix_inverse_fixed #(
    parameter int ENTRY_WIDTH = aff2d_pkg::EntryWidth
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire aff2d_pkg::t_in     i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output aff2d_pkg::t_out         o_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [aff2d_pkg::FracWidth-1:0] i_cfg_data
);
    import aff2d_pkg::*;
    localparam int W = ENTRY_WIDTH;
    localparam int N = NumQuot;
    localparam int L = W + 2;

    logic [FracWidth-1:0] r_frac;
    logic [L-1:0] r_vld;
    logic en;

    assign en = !o_valid || i_ready;
    assign o_ready = en;
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FracReset;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) r_frac <= i_cfg_data;
            if (en) r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    logic signed [W-1:0] d;
    logic [N*W-1:0] num;
    aff2d_front #(.W(W)) u_front (
        .i_clk(i_clk), .i_en(en), .i_frac(r_frac),
        .i_a00(i_data.a00[W-1:0]), .i_a01(i_data.a01[W-1:0]),
        .i_a02(i_data.a02[W-1:0]), .i_a10(i_data.a10[W-1:0]),
        .i_a11(i_data.a11[W-1:0]), .i_a12(i_data.a12[W-1:0]),
        .o_d(d), .o_num(num)
    );

    // sign stage: magnitudes and result signs
    logic [W-1:0] r_dabs;
    logic [N*W-1:0] r_nabs;
    logic [N-1:0] r_neg;
    logic signed [W-1:0] r_d0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dabs <= d[W-1] ? -d : d;
            r_d0 <= d;
            for (int k = 0; k < N; k++) begin
                r_nabs[k*W +: W] <= num[k*W+W-1] ? -num[k*W +: W] : num[k*W +: W];
                r_neg[k] <= num[k*W+W-1] ^ d[W-1];
            end
        end
    end

    logic [W-1:0] c_dabs [W+1];
    logic [N*W-1:0] c_rem [W+1];
    logic [N*W-1:0] c_num [W+1];
    logic [N*W-1:0] c_quo [W+1];
    assign c_dabs[0] = r_dabs;
    assign c_rem[0] = '0;
    assign c_num[0] = r_nabs;
    assign c_quo[0] = '0;

    logic [N-1:0] sg [W+1];
    logic signed [W-1:0] dd [W+1];
    assign sg[0] = r_neg;
    assign dd[0] = r_d0;

    for (genvar g = 0; g < W; g++) begin : g_cell
        aff2d_cell #(.W(W), .N(N)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_dabs(c_dabs[g]), .i_rem(c_rem[g]), .i_num(c_num[g]), .i_quo(c_quo[g]),
            .o_dabs(c_dabs[g+1]), .o_rem(c_rem[g+1]), .o_num(c_num[g+1]),
            .o_quo(c_quo[g+1])
        );
        logic [N-1:0] r_sg;
        logic signed [W-1:0] r_dd;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sg <= sg[g];
                r_dd <= dd[g];
            end
        end
        assign sg[g+1] = r_sg;
        assign dd[g+1] = r_dd;
    end

    logic [W-1:0] q [N];
    logic sing;
    always_comb begin
        sing = (dd[W] == '0);
        for (int k = 0; k < N; k++) begin
            q[k] = sg[W][k] ? -c_quo[W][k*W +: W] : c_quo[W][k*W +: W];
            if (sing) q[k] = '0;
        end
        o_data.status = sing;
        o_data.determinant = 32'(dd[W]);
        o_data.b00 = 32'(signed'(q[5]));
        o_data.b01 = 32'(signed'(q[4]));
        o_data.b02 = 32'(signed'(q[3]));
        o_data.b10 = 32'(signed'(q[2]));
        o_data.b11 = 32'(signed'(q[1]));
        o_data.b12 = 32'(signed'(q[0]));
    end
endmodule
`default_nettype wire

@@ hw/rtl/aff2d_check.sv @@
`default_nettype none
module aff2d_check (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_ready,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire aff2d_pkg::t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status |-> o_data.determinant == 0 && o_data.b00 == 0
        && o_data.b12 == 0)
        else $error("singular result not zero");
    a_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.status |-> o_data.determinant != 0)
        else $error("nonsingular with zero determinant");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stall without pending word");
endmodule
bind affine_2d_matrix_inverse_fixed aff2d_check u_check (.*);
`default_nettype wire
